// File: sv/lcfd_pkg.sv
package lcfd_pkg;

	localparam int unsigned HDR_BYTES       = 8;
	localparam int unsigned HDR_CNT_W       = 4;
	localparam logic [31:0] CRC32C_POLY     = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
	localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;
	localparam int unsigned PADDR_W         = 3;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK  = 2'd0;
	localparam status_t STATUS_LEN = 2'd1;
	localparam status_t STATUS_CRC = 2'd2;

	localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);
	localparam logic [HDR_CNT_W-1:0] HDR_DONE = HDR_CNT_W'(HDR_BYTES);

	// reflected CRC-32C, one byte: eight shift/xor steps flatten to an XOR tree
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: sv/length_crc_frame_deframer.sv
// Length-prefixed frame deframer with CRC-32C check. Each frame is an 8-byte
// header (little-endian payload length, then little-endian CRC-32C of the
// payload) followed by the payload. Header bytes give no beat on the output,
// except the eighth when the length is zero or above max_payload_bytes; that
// raises a sticky invalid-length status. Payload bytes are passed straight
// through, the last one flagged with frame_last and carrying status 2 if the
// CRC does not match (downstream must then drop the frame). After any error
// every input byte gives one beat with data_valid low and the sticky status,
// until reset. Rate: one byte per clock sustained while out_stall is low.
// A byte taken in sits in the input register; its beat is loaded into the
// result register once the output slot is free, and is held there until
// taken. The byte-wide CRC-32C update is a single XOR tree between the two
// registers. max_payload_bytes lives at APB address 0 and should only be
// written while the block is idle.
module length_crc_frame_deframer
	import lcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// APB config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// byte stream in
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [7:0]         rx_byte,
	// result beats out
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         payload_byte,
	output logic               data_valid,
	output logic               frame_last,
	output status_t            status
);

	// config register
	logic [31:0] max_payload_q;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == 1'b0);
	assign prdata  = reg_sel ? max_payload_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_payload_q <= pwdata;
		end
	end

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       fire_s1;

	// output slot is free when empty or draining this cycle
	assign out_free = !out_valid || !out_stall;
	assign fire_s1  = valid_s1 && out_free;
	// take a new byte whenever the input register empties or is empty
	assign rx_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// deframing state
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [31:0]          frame_len_q;
	logic [31:0]          exp_crc_q;
	logic [31:0]          remain_q;
	logic [31:0]          crc_q;
	status_t              err_q;

	logic [HDR_CNT_W-1:0] hdr_cnt_d;
	logic [31:0]          frame_len_d;
	logic [31:0]          exp_crc_d;
	logic [31:0]          remain_d;
	logic [31:0]          crc_d;
	status_t              err_d;

	logic                 res_vld;
	logic [7:0]           res_byte;
	logic                 res_dv;
	logic                 res_last;
	status_t              res_status;

	logic [31:0]          len_full;
	logic [31:0]          crc_upd;
	logic [31:0]          remain_dec;

	// length is complete after the fourth header byte; only read at hdr end
	assign len_full   = frame_len_q;
	assign crc_upd    = crc32c_byte(crc_q, byte_s1);
	assign remain_dec = remain_q - 32'd1;

	always_comb begin
		hdr_cnt_d   = hdr_cnt_q;
		frame_len_d = frame_len_q;
		exp_crc_d   = exp_crc_q;
		remain_d    = remain_q;
		crc_d       = crc_q;
		err_d       = err_q;
		res_vld     = 1'b0;
		res_byte    = 8'd0;
		res_dv      = 1'b0;
		res_last    = 1'b0;
		res_status  = STATUS_OK;

		if (err_q != STATUS_OK) begin
			// sticky error: every byte dropped, one beat each
			res_vld    = 1'b1;
			res_status = err_q;
		end else if (hdr_cnt_q != HDR_DONE) begin
			// header byte: little-endian length then CRC
			if (hdr_cnt_q[2] == 1'b0) begin
				case (hdr_cnt_q[1:0])
					2'd0:    frame_len_d[7:0]   = byte_s1;
					2'd1:    frame_len_d[15:8]  = byte_s1;
					2'd2:    frame_len_d[23:16] = byte_s1;
					default: frame_len_d[31:24] = byte_s1;
				endcase
			end else begin
				case (hdr_cnt_q[1:0])
					2'd0:    exp_crc_d[7:0]   = byte_s1;
					2'd1:    exp_crc_d[15:8]  = byte_s1;
					2'd2:    exp_crc_d[23:16] = byte_s1;
					default: exp_crc_d[31:24] = byte_s1;
				endcase
			end
			hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
			if (hdr_cnt_q == HDR_LAST) begin
				if (len_full == 32'd0 || len_full > max_payload_q) begin
					err_d      = STATUS_LEN;
					res_vld    = 1'b1;
					res_status = STATUS_LEN;
				end else begin
					remain_d = len_full;
					crc_d    = CRC_INIT;
				end
			end
		end else begin
			// payload byte, cut-through
			crc_d    = crc_upd;
			remain_d = remain_dec;
			res_vld  = 1'b1;
			res_byte = byte_s1;
			res_dv   = 1'b1;
			if (remain_dec == 32'd0) begin
				res_last = 1'b1;
				if (~crc_upd != exp_crc_q) begin
					err_d      = STATUS_CRC;
					res_status = STATUS_CRC;
				end
				hdr_cnt_d   = '0;
				frame_len_d = 32'd0;
				exp_crc_d   = 32'd0;
				crc_d       = CRC_INIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			frame_len_q <= 32'd0;
			exp_crc_q   <= 32'd0;
			remain_q    <= 32'd0;
			crc_q       <= CRC_INIT;
			err_q       <= STATUS_OK;
		end else if (fire_s1) begin
			hdr_cnt_q   <= hdr_cnt_d;
			frame_len_q <= frame_len_d;
			exp_crc_q   <= exp_crc_d;
			remain_q    <= remain_d;
			crc_q       <= crc_d;
			err_q       <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= fire_s1 && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_vld) begin
			payload_byte <= res_byte;
			data_valid   <= res_dv;
			frame_last   <= res_last;
			status       <= res_status;
		end
	end

endmodule
